[src/assert_macros.svh]
// assertion helpers used by the rtl file epm_core.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle -> consequent holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in a cycle -> consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/epm_pkg.sv]
package epm_pkg;

    // default sizes of the keyword store
    localparam int MAX_WORD_DEF = 32;
    localparam int MAX_KEYS_DEF = 8;

    // fixed field widths
    localparam int NUM_KEYS_W = 4;
    localparam int WORDS_W    = 4;

    localparam logic [NUM_KEYS_W-1:0] NUM_KEYS_RST = 4'd1;

    // item operations
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TEXT = 2'd1,
        OP_EOD  = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] key_index;
        logic [4:0] char_pos;
        logic [7:0] char_value;
    } in_item_t;

    typedef struct packed {
        logic               phrase_found;
        logic [WORDS_W-1:0] words_matched;
    } out_item_t;

    // ascii upper case to lower case, everything else unchanged
    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        if (c inside {[8'h41:8'h5A]})
            return c + 8'd32;
        return c;
    endfunction

    // ascii letters and digits make up words
    function automatic logic is_word_byte(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

endpackage

[src/epm_ram.sv]
module epm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // one write port, two registered read ports, reads return old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[src/epm_out_buf.sv]
module epm_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  epm_pkg::out_item_t push_data,
    output logic              buf_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output epm_pkg::out_item_t out_data
);
    import epm_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    out_item_t  head_reg;
    out_item_t  head_next;
    out_item_t  tail_reg;
    out_item_t  tail_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = head_reg;
    assign buf_ready = (cnt_reg != 2'd2);
    assign pop       = out_valid && out_ready;

    // two entry queue: head drives the port, tail holds a stalled result
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    head_next = push_data;
                else
                    tail_next = push_data;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                head_next = tail_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default:
            begin
            end
        endcase
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // result storage
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

[src/epm_core.sv]
`include "assert_macros.svh"

module epm_core #(
    parameter int MAX_WORD = epm_pkg::MAX_WORD_DEF,
    parameter int MAX_KEYS = epm_pkg::MAX_KEYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [epm_pkg::NUM_KEYS_W-1:0]  cfg_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  epm_pkg::in_item_t               item,
    output logic                            push,
    output epm_pkg::out_item_t              push_data,
    input  logic                            buf_ready
);
    import epm_pkg::*;

    localparam int WLW   = $clog2(MAX_WORD);
    localparam int KW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int MCW   = $clog2(MAX_KEYS + 1);
    localparam int AW    = KW + WLW;
    localparam int DEPTH = 2 ** AW;

    // matching state
    logic [WLW-1:0]        word_length_reg;
    logic [WLW-1:0]        word_length_next;
    logic                  exp_mis_reg;
    logic                  exp_mis_next;
    logic                  first_mis_reg;
    logic                  first_mis_next;
    logic [MCW-1:0]        match_count_reg;
    logic [MCW-1:0]        match_count_next;
    logic                  found_reg;
    logic                  found_next;
    logic [NUM_KEYS_W-1:0] num_keys_reg;

    // store clearing after reset
    logic                  clr_active_reg;
    logic [AW-1:0]         clr_cnt_reg;

    // store access
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [7:0]            wdata;
    logic [AW-1:0]         raddr_a;
    logic [AW-1:0]         raddr_b;
    logic [7:0]            rdata_a;
    logic [7:0]            rdata_b;
    logic                  fwd_a_reg;
    logic                  fwd_b_reg;
    logic [7:0]            fwd_data_reg;
    logic                  oor_reg;
    logic                  oor_next;
    logic [7:0]            key_a;
    logic [7:0]            key_b;

    logic                  accept;
    logic                  load_ok;
    logic [MCW-1:0]        key_count;
    logic [MCW-1:0]        fin_mc;
    logic                  fin_found;
    logic [MCW-1:0]        res_mc;
    logic                  res_found;
    logic [7:0]            text_c;
    logic [WLW:0]          wl_inc;

    assign cfg_ready  = 1'b1;
    assign item_ready = !clr_active_reg && buf_ready;
    assign accept     = item_valid && item_ready;
    assign push       = accept;

    // keyword store, two read ports: expected keyword and first keyword
    epm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // load decode and write port, the clearing pass takes priority
    always_comb
    begin
        load_ok = accept && (item.op == OP_LOAD)
                  && (32'(item.key_index) < MAX_KEYS) && (32'(item.char_pos) < MAX_WORD);
        if (clr_active_reg)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = 8'd0;
        end
        else
        begin
            we    = load_ok;
            waddr = {KW'(item.key_index), WLW'(item.char_pos)};
            wdata = lower_byte(item.char_value);
        end
    end

    // keyword bytes for the current state, forwarded past a same-address write
    assign key_a = oor_reg ? 8'd0 : (fwd_a_reg ? fwd_data_reg : rdata_a);
    assign key_b = fwd_b_reg ? fwd_data_reg : rdata_b;

    // effective keyword count
    always_comb
    begin
        if (num_keys_reg == '0)
            key_count = MCW'(1);
        else if (32'(num_keys_reg) > MAX_KEYS)
            key_count = MCW'(MAX_KEYS);
        else
            key_count = MCW'(num_keys_reg);
    end

    // outcome of finishing the pending word, an empty word changes nothing
    always_comb
    begin
        if (word_length_reg == '0)
            fin_mc = match_count_reg;
        else if (!exp_mis_reg && (key_a == 8'd0))
            fin_mc = match_count_reg + MCW'(1);
        else if (match_count_reg != '0)
            fin_mc = (!first_mis_reg && (key_b == 8'd0)) ? MCW'(1) : '0;
        else
            fin_mc = match_count_reg;
        fin_found = found_reg || ((word_length_reg != '0) && (fin_mc >= key_count));
    end

    // per item state update and result
    always_comb
    begin
        word_length_next = word_length_reg;
        exp_mis_next     = exp_mis_reg;
        first_mis_next   = first_mis_reg;
        match_count_next = match_count_reg;
        found_next       = found_reg;
        res_mc           = match_count_reg;
        res_found        = found_reg;
        text_c           = lower_byte(item.char_value);
        wl_inc           = {1'b0, word_length_reg} + (WLW + 1)'(1);
        if (accept)
        begin
            case (item.op)
                OP_TEXT:
                begin
                    if (!found_reg)
                    begin
                        if (!is_word_byte(item.char_value))
                        begin
                            match_count_next = fin_mc;
                            found_next       = fin_found;
                            word_length_next = '0;
                            exp_mis_next     = 1'b0;
                            first_mis_next   = 1'b0;
                        end
                        else if (32'(wl_inc) >= MAX_WORD)
                        begin
                            // word too long: drop the partial match
                            match_count_next = '0;
                            word_length_next = '0;
                            exp_mis_next     = 1'b0;
                            first_mis_next   = 1'b0;
                        end
                        else
                        begin
                            exp_mis_next     = exp_mis_reg || (key_a != text_c);
                            first_mis_next   = first_mis_reg || (key_b != text_c);
                            word_length_next = wl_inc[WLW-1:0];
                        end
                    end
                    res_mc    = match_count_next;
                    res_found = found_next;
                end
                OP_EOD:
                begin
                    if (!found_reg)
                    begin
                        res_mc    = fin_mc;
                        res_found = fin_found;
                    end
                    match_count_next = '0;
                    found_next       = 1'b0;
                    word_length_next = '0;
                    exp_mis_next     = 1'b0;
                    first_mis_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        push_data.phrase_found  = res_found;
        push_data.words_matched = WORDS_W'(res_mc);
    end

    // read addresses follow the next state so data lines up with the next item
    assign oor_next = (32'(match_count_next) >= MAX_KEYS);
    assign raddr_a  = {KW'(match_count_next), word_length_next};
    assign raddr_b  = {{KW{1'b0}}, word_length_next};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg <= '0;
            exp_mis_reg     <= 1'b0;
            first_mis_reg   <= 1'b0;
            match_count_reg <= '0;
            found_reg       <= 1'b0;
            num_keys_reg    <= NUM_KEYS_RST;
            clr_active_reg  <= 1'b1;
            clr_cnt_reg     <= '0;
            fwd_a_reg       <= 1'b0;
            fwd_b_reg       <= 1'b0;
            oor_reg         <= 1'b0;
        end
        else
        begin
            word_length_reg <= word_length_next;
            exp_mis_reg     <= exp_mis_next;
            first_mis_reg   <= first_mis_next;
            match_count_reg <= match_count_next;
            found_reg       <= found_next;
            if (cfg_valid)
                num_keys_reg <= cfg_data;
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1)
                    clr_active_reg <= 1'b0;
            end
            fwd_a_reg <= we && (waddr == raddr_a);
            fwd_b_reg <= we && (waddr == raddr_b);
            oor_reg   <= oor_next;
        end
    end

    // forwarded write data
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wdata;
    end

    `ASSERT_IMPLIES(a_found_has_count, clk, rst_n, found_reg, match_count_reg != '0,
        "phrase found with no matched keywords")
    `ASSERT_NEXT(a_eod_clears, clk, rst_n, accept && (item.op == OP_EOD),
        (match_count_reg == '0) && !found_reg && (word_length_reg == '0),
        "end of document left matching state behind")
    `ASSERT_IMPLIES(a_idle_in_clear, clk, rst_n, clr_active_reg, !accept && !load_ok,
        "transaction taken during store clearing")

endmodule

[src/exact_phrase_matcher_top.sv]
// exact phrase matcher
// item channel (item_valid/item_ready/item): op selects a keyword byte load,
// a document text byte or end of document; every item yields one result.
// result channel (result_valid/result_ready/result): phrase_found and
// words_matched as they stand after the item.
// cfg channel (cfg_valid/cfg_ready/cfg_data): number of keywords in the
// phrase, always ready; the user writes it only while no transaction is in
// flight (not enforced by the block). throughput: one item per cycle while
// item_ready is high; store reads use the next state, so keyword data are
// ready for the next item. results are queued as items are accepted. a
// two entry result queue lets one more item in while a result is stalled;
// with both entries full item_ready drops until the receiver takes one.
// reset: matching state clears at once, num_keys returns to 1, then all
// 2**(clog2(MAX_KEYS) + clog2(MAX_WORD)) store entries (256 at the default
// sizes) are zeroed with item_ready low; cfg writes are taken.
module exact_phrase_matcher_top #(
    parameter int MAX_WORD = epm_pkg::MAX_WORD_DEF,
    parameter int MAX_KEYS = epm_pkg::MAX_KEYS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [epm_pkg::NUM_KEYS_W-1:0] cfg_data,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  epm_pkg::in_item_t              item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output epm_pkg::out_item_t             result
);
    import epm_pkg::*;

    logic      push;
    out_item_t push_data;
    logic      buf_ready;

    // matching engine around the keyword store
    epm_core #(
        .MAX_WORD (MAX_WORD),
        .MAX_KEYS (MAX_KEYS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .push_data  (push_data),
        .buf_ready  (buf_ready)
    );

    // result queue
    epm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .buf_ready (buf_ready),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

endmodule
